/* sv/dual_timebase_delay_queue_core_assert.svh */
// assertion macros for the delay queue checker
// expects clk and rst_n in the scope where the macros are used
`ifndef DUAL_TIMEBASE_DELAY_QUEUE_CORE_ASSERT_SVH
`define DUAL_TIMEBASE_DELAY_QUEUE_CORE_ASSERT_SVH

// implication checked on the next edge, skipped during reset
`define DTDQ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("dtdq assertion failed");

// implication checked on the next edge, also across reset
`define DTDQ_ASSERT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("dtdq reset assertion failed");

`endif

/* sv/dtdq_pkg.sv */
// shared types, constants and helpers of the dual timebase delay queue
// no dependencies
package dtdq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RESULT_LIMIT = 32;
  localparam int IW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(2 * QUEUE_DEPTH);
  localparam int NW = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [2:0] {
    ACT_SEND     = 3'd0,
    ACT_TICK     = 3'd1,
    ACT_DEL_NAME = 3'd2,
    ACT_DEL_TYPE = 3'd3,
    ACT_DEL_ENT  = 3'd4,
    ACT_DEL_COMP = 3'd5
  } act_t;

  localparam logic ST_DELIVERED = 1'b0;
  localparam logic ST_DROPPED   = 1'b1;
  localparam logic TB_SYSTEM    = 1'b0;
  localparam logic TB_GAME      = 1'b1;

  typedef struct packed {
    logic [31:0] due;
    logic [7:0]  mtype;
    logic [1:0]  mclass;
    logic [15:0] entity;
    logic [15:0] component;
    logic [15:0] name;
    logic [31:0] payload;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DROP, S_INS_RD, S_INS_CK, S_DEL_RD, S_DEL_CK,
    S_TK_RD, S_TK_CK, S_FLUSH
  } state_t;

  // memory address of logical slot l in queue q whose head sits at h
  function automatic logic [AW-1:0] phys_addr(input logic q, input logic [IW-1:0] h,
                                              input logic [CW-1:0] l);
    logic [AW:0] s;
    s = (AW+1)'(h) + (AW+1)'(l);
    if (s >= (AW+1)'(QUEUE_DEPTH)) s = s - (AW+1)'(QUEUE_DEPTH);
    if (q) s = s + (AW+1)'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction

endpackage

/* sv/dtdq_in_if.sv */
// request channel into the delay queue
// depends on nothing
interface dtdq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic        timebase;
  logic [30:0] delay;
  logic [7:0]  msg_type;
  logic [1:0]  msg_class;
  logic [15:0] entity_id;
  logic [15:0] component_id;
  logic [15:0] name_tag;
  logic [31:0] payload;
  logic [31:0] system_now;
  logic [31:0] game_now;

  modport source (output valid, action, timebase, delay, msg_type, msg_class, entity_id,
                  component_id, name_tag, payload, system_now, game_now, input ready);
  modport sink (input valid, action, timebase, delay, msg_type, msg_class, entity_id,
                component_id, name_tag, payload, system_now, game_now, output ready);
endinterface

/* sv/dtdq_out_if.sv */
// result channel out of the delay queue
// depends on nothing
interface dtdq_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        out_timebase;
  logic [7:0]  out_type;
  logic [1:0]  out_class;
  logic [15:0] out_entity;
  logic [15:0] out_component;
  logic [15:0] out_name;
  logic [31:0] out_payload;
  logic        last;

  modport source (output valid, status, out_timebase, out_type, out_class, out_entity,
                  out_component, out_name, out_payload, last, input ready);
  modport sink (input valid, status, out_timebase, out_type, out_class, out_entity,
                out_component, out_name, out_payload, last, output ready);
endinterface

/* sv/dual_timebase_delay_queue_core.sv */
// channel   dir  modport           carries
// in_chan   in   dtdq_in_if.sink   send, tick and delete requests
// out_chan  out  dtdq_out_if.source delivered messages and drop reports
//
// both queues are rings in one synchronous memory (registered read),
// each with its own head and count. a send walks back from the tail,
// moving each entry that is due later one slot up; a delete compacts
// the kept entries; a tick pops due messages from each queue's head. reset
// (rst_n low, synchronous) empties both queues and zeroes the clocks; no
// clearing pass. the output register lets the core return to idle while
// a result waits; a stalled output holds the tick walk.
// depends on dtdq_pkg, dtdq_in_if, dtdq_out_if
module dual_timebase_delay_queue_core (
  input logic clk,
  input logic rst_n,
  dtdq_in_if.sink    in_chan,
  dtdq_out_if.source out_chan
);
  import dtdq_pkg::*;

  entry_t mem [2*QUEUE_DEPTH];
  entry_t rd_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  entry_t          mem_wdata;

  state_t state_r, state_nxt;
  logic [IW-1:0] head_r [2];
  logic [IW-1:0] head_nxt [2];
  logic [CW-1:0] cnt_r [2];
  logic [CW-1:0] cnt_nxt [2];
  logic [31:0]   tclk_r [2];
  logic [31:0]   tclk_nxt [2];
  entry_t        item_r, item_nxt;
  act_t          act_r, act_nxt;
  logic          q_r, q_nxt;
  logic          both_r, both_nxt;
  logic [CW-1:0] pos_r, pos_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [NW-1:0] n_r, n_nxt;
  entry_t        pend_r, pend_nxt;
  logic          pend_q_r, pend_q_nxt, pend_v_r, pend_v_nxt;
  entry_t        oe_r, oe_nxt;
  logic          ov_r, ov_nxt, ost_r, ost_nxt, otb_r, otb_nxt, olast_r, olast_nxt;

  logic          slot_free, acc, hit;
  logic [32:0]   sum;
  logic [31:0]   due_in;

  assign slot_free = !ov_r || out_chan.ready;
  assign acc = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  assign sum = {2'b00, in_chan.delay} +
               {1'b0, (in_chan.timebase ? tclk_r[1] : tclk_r[0])};
  assign due_in = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  always_comb begin
    unique case (act_r)
      ACT_DEL_NAME: hit = (rd_r.name == item_r.name);
      ACT_DEL_TYPE: hit = (rd_r.mtype == item_r.mtype);
      ACT_DEL_ENT:  hit = (rd_r.entity == item_r.entity);
      ACT_DEL_COMP: hit = (rd_r.component == item_r.component);
      default:      hit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r;
    cnt_nxt = cnt_r;
    tclk_nxt = tclk_r;
    item_nxt = item_r;
    act_nxt = act_r;
    q_nxt = q_r;
    both_nxt = both_r;
    pos_nxt = pos_r;
    i_nxt = i_r;
    j_nxt = j_r;
    n_nxt = n_r;
    pend_nxt = pend_r;
    pend_q_nxt = pend_q_r;
    pend_v_nxt = pend_v_r;
    oe_nxt = oe_r;
    ost_nxt = ost_r;
    otb_nxt = otb_r;
    olast_nxt = olast_r;
    ov_nxt = ov_r && !out_chan.ready;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wdata = item_r;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          item_nxt.due = due_in;
          item_nxt.mtype = in_chan.msg_type;
          item_nxt.mclass = in_chan.msg_class;
          item_nxt.entity = in_chan.entity_id;
          item_nxt.component = in_chan.component_id;
          item_nxt.name = in_chan.name_tag;
          item_nxt.payload = in_chan.payload;
          act_nxt = act_t'(in_chan.action);
          q_nxt = in_chan.timebase;
          both_nxt = 1'b0;
          i_nxt = '0;
          j_nxt = '0;
          priority case (in_chan.action)
            ACT_SEND: begin
              pos_nxt = in_chan.timebase ? cnt_r[1] : cnt_r[0];
              if (pos_nxt == CW'(QUEUE_DEPTH)) state_nxt = S_DROP;
              else state_nxt = S_INS_RD;
            end
            ACT_TICK: begin
              tclk_nxt[0] = in_chan.system_now;
              tclk_nxt[1] = in_chan.game_now;
              q_nxt = TB_SYSTEM;
              n_nxt = '0;
              pend_v_nxt = 1'b0;
              state_nxt = S_TK_RD;
            end
            ACT_DEL_NAME, ACT_DEL_TYPE: state_nxt = S_DEL_RD;
            ACT_DEL_ENT, ACT_DEL_COMP: begin
              q_nxt = TB_GAME;
              both_nxt = 1'b1;
              state_nxt = S_DEL_RD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_DROP: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          oe_nxt = item_r;
          ost_nxt = ST_DROPPED;
          otb_nxt = q_r;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_INS_RD: begin
        if (pos_r == '0) begin
          mem_we = 1'b1;
          mem_waddr = phys_addr(q_r, head_r[q_r], pos_r);
          cnt_nxt[q_r] = cnt_r[q_r] + 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mem_re = 1'b1;
          mem_raddr = phys_addr(q_r, head_r[q_r], pos_r - 1'b1);
          state_nxt = S_INS_CK;
        end
      end

      S_INS_CK: begin
        mem_we = 1'b1;
        mem_waddr = phys_addr(q_r, head_r[q_r], pos_r);
        if (rd_r.due > item_r.due) begin
          mem_wdata = rd_r;
          pos_nxt = pos_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          cnt_nxt[q_r] = cnt_r[q_r] + 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_DEL_RD: begin
        if (i_r == cnt_r[q_r]) begin
          cnt_nxt[q_r] = j_r;
          i_nxt = '0;
          j_nxt = '0;
          if (both_r && q_r == TB_GAME) q_nxt = TB_SYSTEM;
          else state_nxt = S_IDLE;
        end else begin
          mem_re = 1'b1;
          mem_raddr = phys_addr(q_r, head_r[q_r], i_r);
          state_nxt = S_DEL_CK;
        end
      end

      S_DEL_CK: begin
        i_nxt = i_r + 1'b1;
        if (!hit) begin
          mem_we = 1'b1;
          mem_waddr = phys_addr(q_r, head_r[q_r], j_r);
          mem_wdata = rd_r;
          j_nxt = j_r + 1'b1;
        end
        state_nxt = S_DEL_RD;
      end

      S_TK_RD: begin
        if (cnt_r[q_r] == '0 || n_r == NW'(RESULT_LIMIT)) begin
          if (q_r == TB_SYSTEM) q_nxt = TB_GAME;
          else state_nxt = pend_v_r ? S_FLUSH : S_IDLE;
        end else begin
          mem_re = 1'b1;
          mem_raddr = phys_addr(q_r, head_r[q_r], '0);
          state_nxt = S_TK_CK;
        end
      end

      S_TK_CK: begin
        if (rd_r.due <= tclk_r[q_r]) begin
          // hold the entry until the previous one has left
          if (!pend_v_r || slot_free) begin
            if (pend_v_r) begin
              ov_nxt = 1'b1;
              oe_nxt = pend_r;
              ost_nxt = ST_DELIVERED;
              otb_nxt = pend_q_r;
              olast_nxt = 1'b0;
            end
            pend_nxt = rd_r;
            pend_q_nxt = q_r;
            pend_v_nxt = 1'b1;
            head_nxt[q_r] = (head_r[q_r] == IW'(QUEUE_DEPTH - 1)) ? '0 : head_r[q_r] + 1'b1;
            cnt_nxt[q_r] = cnt_r[q_r] - 1'b1;
            n_nxt = n_r + 1'b1;
            state_nxt = S_TK_RD;
          end
        end else if (q_r == TB_SYSTEM) begin
          q_nxt = TB_GAME;
          state_nxt = S_TK_RD;
        end else begin
          state_nxt = pend_v_r ? S_FLUSH : S_IDLE;
        end
      end

      S_FLUSH: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          oe_nxt = pend_r;
          ost_nxt = ST_DELIVERED;
          otb_nxt = pend_q_r;
          olast_nxt = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r[0] <= '0;
      head_r[1] <= '0;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      tclk_r[0] <= '0;
      tclk_r[1] <= '0;
      pend_v_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      cnt_r <= cnt_nxt;
      tclk_r <= tclk_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    act_r <= act_nxt;
    q_r <= q_nxt;
    both_r <= both_nxt;
    pos_r <= pos_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    n_r <= n_nxt;
    pend_r <= pend_nxt;
    pend_q_r <= pend_q_nxt;
    oe_r <= oe_nxt;
    ost_r <= ost_nxt;
    otb_r <= otb_nxt;
    olast_r <= olast_nxt;
  end

  assign out_chan.valid = ov_r;
  assign out_chan.status = ost_r;
  assign out_chan.out_timebase = otb_r;
  assign out_chan.out_type = oe_r.mtype;
  assign out_chan.out_class = oe_r.mclass;
  assign out_chan.out_entity = oe_r.entity;
  assign out_chan.out_component = oe_r.component;
  assign out_chan.out_name = oe_r.name;
  assign out_chan.out_payload = oe_r.payload;
  assign out_chan.last = olast_r;

endmodule

/* sv/dtdq_checker.sv */
// port level checks of the delay queue and their bind to the top level
// depends on dtdq_pkg and dual_timebase_delay_queue_core_assert.svh
`include "dual_timebase_delay_queue_core_assert.svh"

module dtdq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_status,
  input logic        out_last,
  input logic [31:0] out_payload
);
  import dtdq_pkg::*;

  // a request that does work takes the core away from idle
  `DTDQ_ASSERT_NEXT(busy_after_req, in_valid && in_ready && in_action <= ACT_DEL_COMP, !in_ready)
  // a drop report is always the only result of its send
  `DTDQ_ASSERT_NEXT(drop_is_last, out_valid && out_status, out_last)
  // a waiting result keeps its payload
  `DTDQ_ASSERT_NEXT(out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_payload) && $stable(out_last))
  // reset empties the output register
  `DTDQ_ASSERT_RST(out_reset, !rst_n, !out_valid)
endmodule

bind dual_timebase_delay_queue_core dtdq_checker u_dtdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_action  (in_chan.action),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_last   (out_chan.last),
  .out_payload(out_chan.out_payload)
);
